// File: hdl/tlb_and_direct_mapped_cache_core_defines.svh
// assertion macros used by the checker file
`ifndef TLB_AND_DIRECT_MAPPED_CACHE_CORE_DEFINES_SVH
`define TLB_AND_DIRECT_MAPPED_CACHE_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define TDMC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tdmc assertion failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define TDMC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tdmc assertion failed");

`endif

// File: hdl/tdmc_pkg.sv
package tdmc_pkg;

	localparam int VA_W   = 32;
	localparam int PN_W   = 24;
	localparam int TAG_W  = 19;
	localparam int LINE_W = 11;
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 5;

	localparam logic [1:0] MODE_TLB   = 2'd0;
	localparam logic [1:0] MODE_CACHE = 2'd1;
	localparam logic [1:0] MODE_BOTH  = 2'd2;

	localparam logic [CFG_AW-1:0] REG_MODE      = 3'd0;
	localparam logic [CFG_AW-1:0] REG_TLB_USED  = 3'd1;
	localparam logic [CFG_AW-1:0] REG_PAGE_BITS = 3'd2;
	localparam logic [CFG_AW-1:0] REG_LINE_OFF  = 3'd3;
	localparam logic [CFG_AW-1:0] REG_LINE_IDX  = 3'd4;

	localparam logic [3:0] PAGE_BITS_SMALL = 4'd8;
	localparam logic [2:0] LINE_OFF_MAX    = 3'd6;
	localparam logic [3:0] LINE_IDX_MIN    = 4'd8;
	localparam logic [3:0] LINE_IDX_MAX    = 4'd11;
	localparam logic [4:0] TAG_SHIFT_MIN   = 5'd13;

	localparam logic [PN_W-1:0] WALK_MASK_SMALL = 24'hFFF0FF;
	localparam logic [PN_W-1:0] WALK_MASK_LARGE = 24'h0FFF0F;

	typedef struct packed {
		logic [1:0] mode;
		logic [4:0] tlb_used;
		logic [3:0] page_bits;
		logic [2:0] line_off;
		logic [3:0] line_idx;
	} cfg_t;

	typedef struct packed {
		logic accept;
		logic look;
		logic check;
		logic clear;
		logic out_load;
		logic out_from_wait;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
	} stat_t;

endpackage

// File: hdl/tdmc_ctrl.sv
module tdmc_ctrl import tdmc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_LOOK  = 3'd2;
	localparam logic [2:0] ST_CHECK = 3'd3;
	localparam logic [2:0] ST_WAIT  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;
	logic       accept;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) || ((state_q == ST_CHECK) && out_free);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.accept        = accept;
		cmd.look          = (state_q == ST_LOOK);
		cmd.check         = (state_q == ST_CHECK);
		cmd.clear         = (state_q == ST_CLEAR);
		cmd.out_load      = ((state_q == ST_CHECK) || (state_q == ST_WAIT)) && out_free;
		cmd.out_from_wait = (state_q == ST_WAIT);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (stat.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) state_d = ST_LOOK;
			end
			ST_LOOK: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (!out_free) state_d = ST_WAIT;
				else if (accept) state_d = ST_LOOK;
				else state_d = ST_IDLE;
			end
			ST_WAIT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

// File: hdl/tdmc_dp.sv
module tdmc_dp import tdmc_pkg::*; #(
	parameter int TLB_DEPTH   = 16,
	parameter int CACHE_LINES = 2048
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cmd_t            cmd,
	output stat_t           stat,
	input  cfg_t            cfg,
	input  logic [VA_W-1:0] address,
	input  logic            is_data,
	output logic            tlb_hit,
	output logic            cache_hit,
	output logic            page_walk,
	output logic [VA_W-1:0] physical_address,
	output logic            access_is_data
);

	localparam int IW = (CACHE_LINES > 1) ? $clog2(CACHE_LINES) : 1;

	logic [VA_W-1:0] addr_q;
	logic            is_data_q;

	logic            tlb_v_q  [TLB_DEPTH];
	logic [PN_W-1:0] tlb_vp_q [TLB_DEPTH];
	logic [PN_W-1:0] tlb_pp_q [TLB_DEPTH];

	logic            valid_mem [CACHE_LINES];
	logic [TAG_W-1:0] tag_mem  [CACHE_LINES];
	logic            valid_rd_q;
	logic [TAG_W-1:0] tag_rd_q;
	logic [IW-1:0]   clr_cnt_q;

	logic [VA_W-1:0]  pa_q;
	logic             tlb_hit_q;
	logic             walk_q;
	logic [IW-1:0]    slot_q;
	logic [TAG_W-1:0] tag_q;
	logic             hit_q;

	logic             small_pg;
	logic             use_tlb;
	logic [PN_W-1:0]  vpn;
	logic [PN_W-1:0]  walk_ppn;
	logic [PN_W-1:0]  hit_ppn;
	logic [PN_W-1:0]  ppn;
	logic             seen;
	logic             hit_c;
	logic [TLB_DEPTH-1:0] shift_en;
	logic [VA_W-1:0]  pa_c;
	logic             lo6;
	logic [3:0]       li_diff;
	logic [1:0]       li_sel;
	logic [LINE_W-1:0] line_c;
	logic [LINE_W-1:0] idx_mask;
	logic [VA_W-1:0]  slot32;
	logic [IW-1:0]    slot_c;
	logic [4:0]       tag_sh;
	logic [VA_W-1:0]  tag32;
	logic [TAG_W-1:0] tag_c;
	logic             cache_hit_c;
	logic             fill;
	logic             vmem_we;
	logic [IW-1:0]    vmem_addr;

	// tlb search and translation
	always_comb begin
		logic in_use;
		logic match;
		small_pg = (cfg.page_bits == PAGE_BITS_SMALL);
		use_tlb  = (cfg.mode != MODE_CACHE);
		vpn      = small_pg ? addr_q[VA_W-1:8] : {4'b0, addr_q[VA_W-1:12]};
		walk_ppn = ~vpn & (small_pg ? WALK_MASK_SMALL : WALK_MASK_LARGE);
		seen     = 1'b0;
		hit_ppn  = '0;
		shift_en = '0;
		for (int i = 0; i < TLB_DEPTH; i++) begin
			in_use      = (i == 0) || (i < int'(cfg.tlb_used));
			match       = in_use && tlb_v_q[i] && (tlb_vp_q[i] == vpn);
			shift_en[i] = in_use && !seen;
			if (match && !seen) hit_ppn = tlb_pp_q[i];
			seen = seen | match;
		end
		hit_c = seen && use_tlb;
		ppn   = hit_c ? hit_ppn : walk_ppn;
		pa_c  = small_pg ? {ppn, addr_q[7:0]} : {ppn[19:0], addr_q[11:0]};
	end

	// cache geometry
	always_comb begin
		lo6     = (cfg.line_off >= LINE_OFF_MAX);
		li_diff = cfg.line_idx - LINE_IDX_MIN;
		if (cfg.line_idx <= LINE_IDX_MIN) li_sel = 2'd0;
		else if (cfg.line_idx >= LINE_IDX_MAX) li_sel = 2'd3;
		else li_sel = li_diff[1:0];
		line_c   = lo6 ? pa_c[16:6] : pa_c[15:5];
		idx_mask = {LINE_W{1'b1}} >> (2'd3 - li_sel);
		slot32   = {{(VA_W-LINE_W){1'b0}}, line_c & idx_mask};
		slot_c   = slot32[IW-1:0];
		tag_sh   = TAG_SHIFT_MIN + {4'b0, lo6} + {3'b0, li_sel};
		tag32    = pa_c >> tag_sh;
		tag_c    = tag32[TAG_W-1:0];
	end

	assign cache_hit_c = (cfg.mode != MODE_TLB) && valid_rd_q && (tag_rd_q == tag_q);
	assign fill        = cmd.check && (cfg.mode != MODE_TLB) && !cache_hit_c;
	assign vmem_we     = cmd.clear || fill;
	assign vmem_addr   = cmd.clear ? clr_cnt_q : slot_q;
	assign stat.clear_last = (clr_cnt_q == IW'(CACHE_LINES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TLB_DEPTH; i++) tlb_v_q[i] <= 1'b0;
			clr_cnt_q <= '0;
		end else begin
			if (cmd.look && use_tlb) begin
				for (int i = 1; i < TLB_DEPTH; i++) begin
					if (shift_en[i]) tlb_v_q[i] <= tlb_v_q[i-1];
				end
				tlb_v_q[0] <= 1'b1;
			end
			if (cmd.clear) clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			addr_q    <= address;
			is_data_q <= is_data;
		end
		if (cmd.look) begin
			if (use_tlb) begin
				for (int i = 1; i < TLB_DEPTH; i++) begin
					if (shift_en[i]) begin
						tlb_vp_q[i] <= tlb_vp_q[i-1];
						tlb_pp_q[i] <= tlb_pp_q[i-1];
					end
				end
				tlb_vp_q[0] <= vpn;
				tlb_pp_q[0] <= ppn;
			end
			pa_q      <= pa_c;
			tlb_hit_q <= hit_c;
			walk_q    <= !hit_c;
			slot_q    <= slot_c;
			tag_q     <= tag_c;
		end
		if (cmd.check) hit_q <= cache_hit_c;
		if (cmd.out_load) begin
			tlb_hit          <= tlb_hit_q;
			cache_hit        <= cmd.out_from_wait ? hit_q : cache_hit_c;
			page_walk        <= walk_q;
			physical_address <= pa_q;
			access_is_data   <= is_data_q;
		end
	end

	// line valid memory, swept clear after reset
	always_ff @(posedge clk) begin
		if (vmem_we) valid_mem[vmem_addr] <= !cmd.clear;
		if (cmd.look) valid_rd_q <= valid_mem[slot_c];
	end

	always_ff @(posedge clk) begin
		if (fill) tag_mem[slot_q] <= tag_q;
		if (cmd.look) tag_rd_q <= tag_mem[slot_c];
	end

endmodule

// File: hdl/tlb_and_direct_mapped_cache_core.sv
// channel   dir  handshake               payload
// cfg       in   cfg_we                  cfg_index, cfg_data
// in        in   in_valid / in_ready     address, is_data
// out       out  out_valid / out_ready   tlb_hit, cache_hit, page_walk,
//                                        physical_address, access_is_data
//
// a beat goes through the tlb search and cache memory read, then the tag check
// and line fill; the next beat can enter with the check while the output is free
// after reset the line valid memory is swept, with in_ready low
// a stalled output holds one result; the item behind it waits in the wait state
module tlb_and_direct_mapped_cache_core import tdmc_pkg::*; #(
	parameter int TLB_DEPTH   = 16,
	parameter int CACHE_LINES = 2048
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [VA_W-1:0]   address,
	input  logic              is_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              tlb_hit,
	output logic              cache_hit,
	output logic              page_walk,
	output logic [VA_W-1:0]   physical_address,
	output logic              access_is_data
);

	cfg_t  cfg_q;
	cmd_t  cmd;
	stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode      <= MODE_BOTH;
			cfg_q.tlb_used  <= 5'd16;
			cfg_q.page_bits <= 4'd12;
			cfg_q.line_off  <= 3'd5;
			cfg_q.line_idx  <= 4'd8;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:      cfg_q.mode      <= cfg_data[1:0];
				REG_TLB_USED:  cfg_q.tlb_used  <= cfg_data[4:0];
				REG_PAGE_BITS: cfg_q.page_bits <= cfg_data[3:0];
				REG_LINE_OFF:  cfg_q.line_off  <= cfg_data[2:0];
				REG_LINE_IDX:  cfg_q.line_idx  <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	tdmc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	tdmc_dp #(
		.TLB_DEPTH   (TLB_DEPTH),
		.CACHE_LINES (CACHE_LINES)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.cfg              (cfg_q),
		.address          (address),
		.is_data          (is_data),
		.tlb_hit          (tlb_hit),
		.cache_hit        (cache_hit),
		.page_walk        (page_walk),
		.physical_address (physical_address),
		.access_is_data   (access_is_data)
	);

endmodule

// File: hdl/tdmc_checker.sv
`include "tlb_and_direct_mapped_cache_core_defines.svh"

module tdmc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        tlb_hit,
	input logic        page_walk,
	input logic [31:0] physical_address
);

	`TDMC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(physical_address))
	`TDMC_ASSERT_IMP(a_walk_or_hit, out_valid, page_walk != tlb_hit)
	`TDMC_ASSERT_NEXT(a_busy_after_beat, in_valid && in_ready, !in_ready)

endmodule

bind tlb_and_direct_mapped_cache_core tdmc_checker u_chk (.*);

// File: dv/testbench.sv
module testbench;
	import tdmc_pkg::*;

	localparam int TLB_DEPTH   = 16;
	localparam int CACHE_LINES = 2048;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	typedef struct packed {
		logic            tlb_hit;
		logic            cache_hit;
		logic            page_walk;
		logic [VA_W-1:0] physical_address;
		logic            access_is_data;
	} lookup_t;

	typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		logic [CFG_AW-1:0] reg_sel;
		logic [CFG_DW-1:0] value;
		logic [VA_W-1:0]   va;
		logic              d;
		logic              typed;
		lookup_t           want;
	} stim_row_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [CFG_AW-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_data;
	logic              in_valid;
	logic              in_ready;
	logic [VA_W-1:0]   address;
	logic              is_data;
	logic              out_valid;
	logic              out_ready;
	logic              tlb_hit;
	logic              cache_hit;
	logic              page_walk;
	logic [VA_W-1:0]   physical_address;
	logic              access_is_data;

	// predictor state
	cfg_t            cur_cfg = '{MODE_BOTH, 5'd16, 4'd12, 3'd5, 4'd8};
	bit              tlb_valid [TLB_DEPTH];
	logic [PN_W-1:0] tlb_vpage [TLB_DEPTH];
	logic [PN_W-1:0] tlb_ppage [TLB_DEPTH];
	bit              line_valid [CACHE_LINES];
	logic [TAG_W-1:0] line_tag [CACHE_LINES];

	lookup_t         expected_lookups [$];
	stim_row_t       directed_rows [$];
	cfg_t            phase_cfgs [12];
	logic [VA_W-1:0] hot_addrs [24];
	int              mismatch_count = 0;
	int              send_idle_pct = 37;
	int              recv_idle_pct = 51;

	tlb_and_direct_mapped_cache_core #(
		.TLB_DEPTH(TLB_DEPTH),
		.CACHE_LINES(CACHE_LINES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.address(address),
		.is_data(is_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.tlb_hit(tlb_hit),
		.cache_hit(cache_hit),
		.page_walk(page_walk),
		.physical_address(physical_address),
		.access_is_data(access_is_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic lookup_t predict_lookup(input logic [VA_W-1:0] va, input logic d);
		lookup_t r;
		logic small_pages;
		logic hit;
		int off, depth, h, lo, li, i;
		logic [PN_W-1:0] vpn, ppn;
		logic [VA_W-1:0] pa;
		logic [LINE_W-1:0] slot;
		logic [TAG_W-1:0] tag;
		r = '0;
		small_pages = (cur_cfg.page_bits == PAGE_BITS_SMALL);
		off = small_pages ? 8 : 12;
		vpn = PN_W'(va >> off);
		if (cur_cfg.mode == MODE_CACHE) begin
			ppn = ~vpn & (small_pages ? WALK_MASK_SMALL : WALK_MASK_LARGE);
			r.page_walk = 1'b1;
		end else begin
			depth = (cur_cfg.tlb_used < 1) ? 1 :
				((cur_cfg.tlb_used > TLB_DEPTH) ? TLB_DEPTH : int'(cur_cfg.tlb_used));
			hit = 1'b0;
			h = depth - 1;
			for (i = 0; i < depth; i++) begin
				if (!hit && tlb_valid[i] && tlb_vpage[i] == vpn) begin
					hit = 1'b1;
					h = i;
				end
			end
			if (hit) begin
				ppn = tlb_ppage[h];
			end else begin
				ppn = ~vpn & (small_pages ? WALK_MASK_SMALL : WALK_MASK_LARGE);
				r.page_walk = 1'b1;
			end
			// most recently used entry goes to the front
			for (i = h; i > 0; i--) begin
				tlb_valid[i] = tlb_valid[i-1];
				tlb_vpage[i] = tlb_vpage[i-1];
				tlb_ppage[i] = tlb_ppage[i-1];
			end
			tlb_valid[0] = 1'b1;
			tlb_vpage[0] = vpn;
			tlb_ppage[0] = ppn;
			r.tlb_hit = hit;
		end
		pa = (VA_W'(ppn) << off) | (va & ((VA_W'(1) << off) - 1));
		if (cur_cfg.mode != MODE_TLB) begin
			lo = (cur_cfg.line_off < 5) ? 5 :
				((cur_cfg.line_off > LINE_OFF_MAX) ? int'(LINE_OFF_MAX) : int'(cur_cfg.line_off));
			li = (cur_cfg.line_idx < LINE_IDX_MIN) ? int'(LINE_IDX_MIN) :
				((cur_cfg.line_idx > LINE_IDX_MAX) ? int'(LINE_IDX_MAX) : int'(cur_cfg.line_idx));
			slot = LINE_W'((pa >> lo) & ((VA_W'(1) << li) - 1));
			tag = TAG_W'(pa >> (lo + li));
			if (line_valid[slot] && line_tag[slot] == tag) begin
				r.cache_hit = 1'b1;
			end else begin
				line_valid[slot] = 1'b1;
				line_tag[slot] = tag;
			end
		end
		r.physical_address = pa;
		r.access_is_data = d;
		return r;
	endfunction

	function automatic stim_row_t beat_row(input logic [VA_W-1:0] va, input logic d);
		stim_row_t r;
		r = '0;
		r.kind = ROW_BEAT;
		r.va = va;
		r.d = d;
		return r;
	endfunction

	function automatic stim_row_t typed_row(input logic [VA_W-1:0] va, input logic d,
			input logic th, input logic ch, input logic pw, input logic [VA_W-1:0] pa);
		stim_row_t r;
		r = beat_row(va, d);
		r.typed = 1'b1;
		r.want = '{th, ch, pw, pa, d};
		return r;
	endfunction

	function automatic stim_row_t cfg_row(input logic [CFG_AW-1:0] idx,
			input logic [CFG_DW-1:0] val);
		stim_row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.reg_sel = idx;
		r.value = val;
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [VA_W-1:0] got,
			input logic [VA_W-1:0] want);
		if (mismatch_count < 50)
			$display("mismatch on %s: got %h, want %h", field, got, want);
		mismatch_count++;
	endtask

	task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_MODE:      cur_cfg.mode = val[1:0];
			REG_TLB_USED:  cur_cfg.tlb_used = val;
			REG_PAGE_BITS: cur_cfg.page_bits = val[3:0];
			REG_LINE_OFF:  cur_cfg.line_off = val[2:0];
			REG_LINE_IDX:  cur_cfg.line_idx = val[3:0];
			default: ;
		endcase
	endtask

	task automatic send_beat(input logic [VA_W-1:0] va, input logic d, input logic typed,
			input lookup_t want);
		lookup_t predicted;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		address <= va;
		is_data <= d;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predicted = predict_lookup(va, d);
		expected_lookups.push_back(typed ? want : predicted);
	endtask

	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (expected_lookups.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// receiver side: random stalls, check each beat against the oldest expectation
	initial begin
		lookup_t want;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (expected_lookups.size() == 0) begin
					report_mismatch("unexpected beat", physical_address, '0);
				end else begin
					want = expected_lookups.pop_front();
					if (tlb_hit !== want.tlb_hit)
						report_mismatch("tlb_hit", VA_W'(tlb_hit), VA_W'(want.tlb_hit));
					if (cache_hit !== want.cache_hit)
						report_mismatch("cache_hit", VA_W'(cache_hit), VA_W'(want.cache_hit));
					if (page_walk !== want.page_walk)
						report_mismatch("page_walk", VA_W'(page_walk), VA_W'(want.page_walk));
					if (physical_address !== want.physical_address)
						report_mismatch("physical_address", physical_address,
							want.physical_address);
					if (access_is_data !== want.access_is_data)
						report_mismatch("access_is_data", VA_W'(access_is_data),
							VA_W'(want.access_is_data));
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		int i, p, k, pick;
		logic [VA_W-1:0] va;
		logic prev_beat;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		address <= '0;
		is_data <= 1'b0;

		directed_rows = '{
			typed_row(32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b1, 32'hFFF0_F000),
			typed_row(32'h0000_0000, 1'b0, 1'b1, 1'b1, 1'b0, 32'hFFF0_F000),
			typed_row(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b1, 32'h0000_0FFF),
			typed_row(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b0, 32'h0000_0FFF),
			beat_row(32'h0000_0020, 1'b0),
			beat_row(32'h1234_5678, 1'b1),
			cfg_row(REG_MODE, CFG_DW'(MODE_TLB)),
			typed_row(32'h0000_0000, 1'b0, 1'b1, 1'b0, 1'b0, 32'hFFF0_F000),
			beat_row(32'hAAAA_AAAA, 1'b1),
			cfg_row(REG_MODE, CFG_DW'(MODE_CACHE)),
			beat_row(32'h0000_0000, 1'b0),
			beat_row(32'h5555_5555, 1'b1),
			cfg_row(REG_MODE, CFG_DW'(MODE_SPARE)),
			beat_row(32'h5555_5555, 1'b0),
			// tlb keeps large page entries across the page size switch
			cfg_row(REG_PAGE_BITS, CFG_DW'(PAGE_BITS_SMALL)),
			beat_row(32'h0000_0000, 1'b0),
			beat_row(32'hFFFF_FFFF, 1'b1),
			cfg_row(REG_TLB_USED, 5'd1),
			beat_row(32'h0000_0100, 1'b0),
			beat_row(32'h0000_0100, 1'b1),
			beat_row(32'h0000_0200, 1'b0),
			cfg_row(REG_TLB_USED, 5'd0),
			beat_row(32'h0000_0100, 1'b0),
			cfg_row(REG_TLB_USED, 5'd31),
			beat_row(32'h0000_0300, 1'b1),
			cfg_row(REG_PAGE_BITS, 5'd0),
			cfg_row(REG_LINE_OFF, 5'd0),
			cfg_row(REG_LINE_IDX, 5'd0),
			beat_row(32'hFFFF_FFFF, 1'b0),
			cfg_row(REG_PAGE_BITS, 5'd15),
			cfg_row(REG_LINE_OFF, 5'd7),
			cfg_row(REG_LINE_IDX, 5'd15),
			beat_row(32'h0000_0000, 1'b1),
			beat_row(32'hFFFF_FFFF, 1'b1),
			beat_row(32'hFFFF_FFFF, 1'b0)
		};

		phase_cfgs = '{
			'{MODE_BOTH,  5'd16, 4'd12, 3'd5, 4'd8},
			'{MODE_TLB,   5'd4,  4'd8,  3'd5, 4'd8},
			'{MODE_CACHE, 5'd16, 4'd12, 3'd6, 4'd11},
			'{MODE_SPARE, 5'd1,  4'd8,  3'd5, 4'd11},
			'{MODE_BOTH,  5'd31, 4'd9,  3'd7, 4'd15},
			'{MODE_BOTH,  5'd0,  4'd12, 3'd0, 4'd0},
			'{MODE_TLB,   5'd16, 4'd12, 3'd5, 4'd8},
			'{MODE_CACHE, 5'd8,  4'd8,  3'd6, 4'd9},
			'{MODE_BOTH,  5'd2,  4'd12, 3'd5, 4'd10},
			'{MODE_SPARE, 5'd12, 4'd4,  3'd6, 4'd8},
			'{MODE_BOTH,  5'd16, 4'd8,  3'd5, 4'd8},
			'{MODE_BOTH,  5'd7,  4'd12, 3'd6, 4'd11}
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		prev_beat = 1'b0;
		for (i = 0; i < directed_rows.size(); i++) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				if (prev_beat)
					drain_pipeline();
				write_reg(directed_rows[i].reg_sel, directed_rows[i].value);
				if (i + 1 == directed_rows.size() || directed_rows[i+1].kind != ROW_CFG)
					cfg_we <= 1'b0;
				prev_beat = 1'b0;
			end else begin
				send_beat(directed_rows[i].va, directed_rows[i].d, directed_rows[i].typed,
					directed_rows[i].want);
				prev_beat = 1'b1;
			end
		end

		for (p = 0; p < $size(phase_cfgs); p++) begin
			send_idle_pct = (p < 4) ? 37 : ((p < 8) ? 51 : 0);
			recv_idle_pct = (p < 4) ? 51 : ((p < 8) ? 37 : 0);
			drain_pipeline();
			write_reg(REG_MODE, {3'($urandom), phase_cfgs[p].mode});
			write_reg(REG_TLB_USED, phase_cfgs[p].tlb_used);
			write_reg(REG_PAGE_BITS, {1'($urandom), phase_cfgs[p].page_bits});
			write_reg(REG_LINE_OFF, {2'($urandom), phase_cfgs[p].line_off});
			write_reg(REG_LINE_IDX, {1'($urandom), phase_cfgs[p].line_idx});
			// unmapped register indexes are ignored
			if (p == 0) begin
				for (k = 1; k < 4; k++)
					write_reg(REG_LINE_IDX + CFG_AW'(k), CFG_DW'($urandom));
			end
			cfg_we <= 1'b0;
			foreach (hot_addrs[k])
				hot_addrs[k] = $urandom;
			repeat (50) begin
				pick = $urandom_range(99);
				va = hot_addrs[$urandom_range($size(hot_addrs) - 1)];
				if (pick < 45)
					va = va ^ VA_W'($urandom_range(31));
				else if (pick < 75)
					va = {va[VA_W-1:12], 12'($urandom)};
				else if (pick < 90)
					va = va ^ (VA_W'(1) << $urandom_range(VA_W - 1));
				else
					va = $urandom;
				send_beat(va, 1'($urandom), 1'b0, '0);
			end
		end
		drain_pipeline();

		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
